/* rtl/refcounted_frame_stack_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame stack allocator RTL.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNTED_FRAME_STACK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define RFSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rfsa_pkg.sv */
// ----------------------------------------------------------------------------
// rfsa_pkg
// Field widths, table depth, operation codes and status codes of the frame
// stack allocator.
// ----------------------------------------------------------------------------
package rfsa_pkg;

	localparam int OP_W     = 2;
	localparam int OFF_W    = 21;
	localparam int HANDLE_W = 6;
	localparam int STATUS_W = 3;
	localparam int LIVE_W   = 7;

	localparam int MAX_FRAMES = 64;

	localparam logic [OFF_W-1:0] CAP_RESET = 21'd1048576;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_REF     = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_LOCATE  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

endpackage

/* rtl/refcounted_frame_stack_allocator_core.sv */
// ----------------------------------------------------------------------------
// refcounted_frame_stack_allocator_core
// Stack of reference-counted frames in a byte region: allocate, reference,
// release with pop of unreferenced top frames, and locate.
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat contents
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | operation, frame_size, handle
//  out      | out_valid / out_stall| status, frame_handle, payload_offset,
//           |                      | marker_offset, frames_live, top_offset
//  cfg      | cfg_valid / cfg_ready| cfg_data (capacity_bytes)
//
// Allocate checks for a full table, forms the marker offset and frame end, then checks the
// capacity; the others check the handle and read the entry, then all but locate update the
// count; a popping release pops unreferenced top frames. One shared adder serves all steps.
// One item is in work at a time; in_stall is high until the result is loaded, and a result
// held under out_stall delays that load. Reset empties the stack and
// restores the capacity; the frame table is not cleared, entries above the count are unread.
// ----------------------------------------------------------------------------
`include "refcounted_frame_stack_allocator_core_macros.svh"

module refcounted_frame_stack_allocator_core #(
	parameter int MARKER_BYTES = 24,
	parameter int COUNT_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rfsa_pkg::OP_W-1:0]          operation,
	input  logic [rfsa_pkg::OFF_W-1:0]         frame_size,
	input  logic [rfsa_pkg::HANDLE_W-1:0]      handle,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rfsa_pkg::STATUS_W-1:0]      status,
	output logic [rfsa_pkg::HANDLE_W-1:0]      frame_handle,
	output logic [rfsa_pkg::OFF_W-1:0]         payload_offset,
	output logic [rfsa_pkg::OFF_W-1:0]         marker_offset,
	output logic [rfsa_pkg::LIVE_W-1:0]        frames_live,
	output logic [rfsa_pkg::OFF_W-1:0]         top_offset,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rfsa_pkg::OFF_W-1:0]         cfg_data
);

	localparam int IDX_W = $clog2(rfsa_pkg::MAX_FRAMES);
	localparam int CNT_W = $clog2(rfsa_pkg::MAX_FRAMES + 1);
	localparam int CMP_W = (CNT_W > rfsa_pkg::HANDLE_W) ? CNT_W : rfsa_pkg::HANDLE_W;
	localparam int ALU_W = (COUNT_BITS + 1 > rfsa_pkg::OFF_W + 2) ?
		COUNT_BITS + 1 : rfsa_pkg::OFF_W + 2;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CNT_W-1:0]      FC_FULL = CNT_W'(rfsa_pkg::MAX_FRAMES);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ALC_A   = 4'd1;
	localparam logic [3:0] S_ALC_B   = 4'd2;
	localparam logic [3:0] S_ALC_C   = 4'd3;
	localparam logic [3:0] S_H_CHK   = 4'd4;
	localparam logic [3:0] S_H_RD    = 4'd5;
	localparam logic [3:0] S_H_CNT   = 4'd6;
	localparam logic [3:0] S_POP_RD  = 4'd7;
	localparam logic [3:0] S_POP_CHK = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	logic [3:0]                      state_q;
	logic [rfsa_pkg::OFF_W-1:0]      capacity_q;
	logic [CNT_W-1:0]                frame_count_q;
	logic [rfsa_pkg::OFF_W-1:0]      stack_top_q;

	logic [rfsa_pkg::OP_W-1:0]       op_q;
	logic [rfsa_pkg::OFF_W-1:0]      fsize_q;
	logic [rfsa_pkg::HANDLE_W-1:0]   handle_q;
	logic [rfsa_pkg::STATUS_W-1:0]   status_q;
	logic [rfsa_pkg::HANDLE_W-1:0]   fh_q;
	logic [rfsa_pkg::OFF_W-1:0]      pay_q;
	logic [ALU_W-1:0]                mark_q;
	logic [ALU_W-1:0]                need_q;
	logic [COUNT_BITS-1:0]           count_q;

	logic                            out_valid_q;
	logic [rfsa_pkg::STATUS_W-1:0]   out_status_q;
	logic [rfsa_pkg::HANDLE_W-1:0]   out_fh_q;
	logic [rfsa_pkg::OFF_W-1:0]      out_pay_q;
	logic [rfsa_pkg::OFF_W-1:0]      out_mark_q;
	logic [rfsa_pkg::LIVE_W-1:0]     out_live_q;
	logic [rfsa_pkg::OFF_W-1:0]      out_top_q;

	logic [rfsa_pkg::OFF_W-1:0]      marker_mem [rfsa_pkg::MAX_FRAMES];
	logic [rfsa_pkg::OFF_W-1:0]      size_mem   [rfsa_pkg::MAX_FRAMES];
	logic [COUNT_BITS-1:0]           count_mem  [rfsa_pkg::MAX_FRAMES];
	logic [rfsa_pkg::OFF_W-1:0]      marker_rd_q;
	logic [rfsa_pkg::OFF_W-1:0]      size_rd_q;
	logic [COUNT_BITS-1:0]           count_rd_q;

	logic                            in_fire;
	logic                            out_free;
	logic [CMP_W-1:0]                h_cmp;
	logic [CMP_W-1:0]                fc_cmp;
	logic [IDX_W-1:0]                hnd_idx;
	logic [IDX_W-1:0]                top_idx;
	logic [IDX_W-1:0]                rd_idx;
	logic [IDX_W-1:0]                cnt_widx;
	logic                            alloc_we;
	logic                            cnt_we;
	logic [COUNT_BITS-1:0]           cnt_wdata;
	logic                            ref_sat;

	logic [ALU_W-1:0]                alu_a;
	logic [ALU_W-1:0]                alu_b;
	logic                            alu_sub;
	logic [ALU_W:0]                  alu_res;
	logic                            alu_carry;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign h_cmp   = CMP_W'(handle_q);
	assign fc_cmp  = CMP_W'(frame_count_q);
	assign hnd_idx = IDX_W'(h_cmp);
	assign top_idx = IDX_W'(frame_count_q - CNT_W'(1));
	assign rd_idx  = (state_q == S_POP_RD) ? top_idx : hnd_idx;
	assign ref_sat = (count_q == CNT_MAX);

	// shared adder / subtractor
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_ALC_A: begin
				alu_a = ALU_W'(stack_top_q);
				alu_b = ALU_W'(fsize_q);
			end
			S_ALC_B: begin
				alu_a = mark_q;
				alu_b = ALU_W'(MARKER_BYTES);
			end
			S_ALC_C: begin
				alu_a   = ALU_W'(capacity_q);
				alu_b   = need_q;
				alu_sub = 1'b1;
			end
			S_H_RD, S_POP_CHK: begin
				alu_a   = ALU_W'(marker_rd_q);
				alu_b   = ALU_W'(size_rd_q);
				alu_sub = 1'b1;
			end
			S_H_CNT: begin
				alu_a   = ALU_W'(count_q);
				alu_b   = ALU_W'(1);
				alu_sub = (op_q != rfsa_pkg::OP_REF);
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (ALU_W + 1)'(alu_sub);
	assign alu_carry = alu_res[ALU_W];

	assign alloc_we  = (state_q == S_ALC_C) && alu_carry;
	assign cnt_we    = alloc_we ||
		((state_q == S_H_CNT) && !((op_q == rfsa_pkg::OP_REF) && ref_sat));
	assign cnt_wdata = alloc_we ? COUNT_BITS'(1) : alu_res[COUNT_BITS-1:0];
	assign cnt_widx  = alloc_we ? IDX_W'(frame_count_q) : hnd_idx;

	// frame table
	always_ff @(posedge clk) begin
		if (alloc_we) begin
			marker_mem[IDX_W'(frame_count_q)] <= mark_q[rfsa_pkg::OFF_W-1:0];
			size_mem[IDX_W'(frame_count_q)]   <= fsize_q;
		end
		if (cnt_we) begin
			count_mem[cnt_widx] <= cnt_wdata;
		end
		marker_rd_q <= marker_mem[rd_idx];
		size_rd_q   <= size_mem[rd_idx];
		count_rd_q  <= count_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			capacity_q    <= rfsa_pkg::CAP_RESET;
			frame_count_q <= '0;
			stack_top_q   <= '0;
			out_valid_q   <= 1'b0;
			op_q          <= '0;
			fsize_q       <= '0;
			handle_q      <= '0;
			status_q      <= rfsa_pkg::ST_OK;
			fh_q          <= '0;
			pay_q         <= '0;
			mark_q        <= '0;
			need_q        <= '0;
			count_q       <= '0;
			out_status_q  <= rfsa_pkg::ST_OK;
			out_fh_q      <= '0;
			out_pay_q     <= '0;
			out_mark_q    <= '0;
			out_live_q    <= '0;
			out_top_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q     <= operation;
						fsize_q  <= frame_size;
						handle_q <= handle;
						status_q <= rfsa_pkg::ST_OK;
						fh_q     <= (operation == rfsa_pkg::OP_ALLOC) ? '0 : handle;
						pay_q    <= '0;
						mark_q   <= '0;
						state_q  <= (operation == rfsa_pkg::OP_ALLOC) ? S_ALC_A : S_H_CHK;
					end
				end
				S_ALC_A: begin
					if (frame_count_q >= FC_FULL) begin
						status_q <= rfsa_pkg::ST_TABLE_FULL;
						state_q  <= S_DONE;
					end else begin
						mark_q  <= alu_res[ALU_W-1:0];
						state_q <= S_ALC_B;
					end
				end
				S_ALC_B: begin
					need_q  <= alu_res[ALU_W-1:0];
					state_q <= S_ALC_C;
				end
				S_ALC_C: begin
					if (alu_carry) begin
						pay_q         <= stack_top_q;
						fh_q          <= rfsa_pkg::HANDLE_W'(frame_count_q);
						frame_count_q <= frame_count_q + CNT_W'(1);
						stack_top_q   <= need_q[rfsa_pkg::OFF_W-1:0];
					end else begin
						status_q <= rfsa_pkg::ST_NO_SPACE;
						mark_q   <= '0;
					end
					state_q <= S_DONE;
				end
				S_H_CHK: begin
					if (h_cmp >= fc_cmp) begin
						status_q <= rfsa_pkg::ST_BAD_HANDLE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_H_RD;
					end
				end
				S_H_RD: begin
					if (count_rd_q == '0) begin
						status_q <= rfsa_pkg::ST_BAD_HANDLE;
						state_q  <= S_DONE;
					end else begin
						pay_q   <= alu_res[rfsa_pkg::OFF_W-1:0];
						mark_q  <= ALU_W'(marker_rd_q);
						count_q <= count_rd_q;
						state_q <= (op_q == rfsa_pkg::OP_LOCATE) ? S_DONE : S_H_CNT;
					end
				end
				S_H_CNT: begin
					state_q <= S_DONE;
					if (op_q == rfsa_pkg::OP_REF) begin
						if (ref_sat) begin
							status_q <= rfsa_pkg::ST_OVERFLOW;
							pay_q    <= '0;
							mark_q   <= '0;
						end
					end else if ((alu_res[COUNT_BITS-1:0] == '0) &&
							(h_cmp + CMP_W'(1) == fc_cmp)) begin
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: begin
					if (frame_count_q == '0) begin
						stack_top_q <= '0;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_POP_CHK;
					end
				end
				S_POP_CHK: begin
					if (count_rd_q != '0) begin
						state_q <= S_DONE;
					end else begin
						stack_top_q   <= alu_res[rfsa_pkg::OFF_W-1:0];
						frame_count_q <= frame_count_q - CNT_W'(1);
						state_q       <= S_POP_RD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_fh_q     <= fh_q;
						out_pay_q    <= pay_q;
						out_mark_q   <= mark_q[rfsa_pkg::OFF_W-1:0];
						out_live_q   <= rfsa_pkg::LIVE_W'(frame_count_q);
						out_top_q    <= stack_top_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign frame_handle   = out_fh_q;
	assign payload_offset = out_pay_q;
	assign marker_offset  = out_mark_q;
	assign frames_live    = out_live_q;
	assign top_offset     = out_top_q;

	`RFSA_ASSERT_NOW(a_fc_bound, clk, arst_n, 1'b1, frame_count_q <= FC_FULL,
		"frame count above table depth")
	`RFSA_ASSERT_NOW(a_empty_top, clk, arst_n, (state_q == S_IDLE) && (frame_count_q == '0),
		stack_top_q == '0, "empty stack with nonzero top")
	`RFSA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_fire, state_q != S_IDLE,
		"accepted beat left sequencer idle")
	`RFSA_ASSERT_NOW(a_status_range, clk, arst_n, out_valid_q,
		out_status_q <= rfsa_pkg::ST_OVERFLOW, "status code out of range")

endmodule
